>>> hw/rtl/mbas_pkg.sv
// ----------------------------------------------------------------------------
// mbas_pkg
// Shared types, constants and tables of the multi-background alpha split.
// ----------------------------------------------------------------------------
`default_nettype none

package mbas_pkg;

  localparam int unsigned BgCount = 9;
  localparam int unsigned ChanCount = 3;
  localparam logic [15:0] FullPm = 16'd65025;
  localparam int unsigned CommonDen = 2520;
  // 3 * 65025 * 2520
  localparam logic [28:0] ThreeDen = 29'd491589000;
  // 65025 * 2520 / 85
  localparam logic [20:0] AlphaDiv = 21'd1927800;
  // floor(2^48 / AlphaDiv)
  localparam logic [27:0] AlphaRecip = 28'd146008391;
  localparam int unsigned RecipShift = 48;
  // floor(x / 255) = (x * 32897) >> 23 for 16-bit x
  localparam logic [15:0] Div255Mul = 16'd32897;
  localparam int unsigned Div255Shift = 23;

  typedef struct packed {
    logic [31:0] sample_bg8;
    logic [31:0] sample_bg7;
    logic [31:0] sample_bg6;
    logic [31:0] sample_bg5;
    logic [31:0] sample_bg4;
    logic [31:0] sample_bg3;
    logic [31:0] sample_bg2;
    logic [31:0] sample_bg1;
    logic [31:0] sample_bg0;
  } in_t;

  typedef struct packed {
    logic [7:0] add_blue;
    logic [7:0] add_green;
    logic [7:0] add_red;
    logic [7:0] blend_alpha;
  } out_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic s3_en;
    logic s4_en;
    logic s5_en;
  } merge_ctrl_t;

  // slope scale for the first full background idx; idx 9 means none full
  function automatic logic [14:0] slope_factor(input logic [3:0] idx);
    logic [14:0] f;
    case (idx)
      4'd0:    f = 15'd22680;
      4'd1:    f = 15'd11340;
      4'd2:    f = 15'd7560;
      4'd3:    f = 15'd5670;
      4'd4:    f = 15'd4536;
      4'd5:    f = 15'd3780;
      4'd6:    f = 15'd3240;
      4'd7:    f = 15'd2835;
      4'd8:    f = 15'd2520;
      default: f = 15'(CommonDen);
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mbas_lane.sv
// ----------------------------------------------------------------------------
// mbas_lane
// One color channel: premultiply, find first full background, form slope and add value.
// ----------------------------------------------------------------------------
`default_nettype none

module mbas_lane (
  input  wire logic                      clk_i,
  input  wire mbas_pkg::lane_ctrl_t      ctrl_i,
  input  wire logic [8:0][7:0]           col_i,
  input  wire logic [8:0][7:0]           alpha_i,
  output logic signed [31:0]             slope_o,
  output logic [7:0]                     add_o
);

  logic [8:0][15:0] pm_q;
  logic [3:0]       sel;
  logic [15:0]      pm_sel;
  logic signed [16:0] diff;
  logic signed [31:0] slope_d, slope_q;
  logic [31:0]      add_prod;
  logic [7:0]       add_d, add_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_en) begin
      for (int j = 0; j < 9; j++) begin
        pm_q[j] <= col_i[j] * alpha_i[j];
      end
    end
  end

  always_comb begin
    sel = 4'd9;
    for (int j = 8; j >= 0; j--) begin
      if (pm_q[j] == mbas_pkg::FullPm) begin
        sel = 4'(j);
      end
    end
    pm_sel   = (sel == 4'd9) ? pm_q[8] : pm_q[sel];
    diff     = $signed({1'b0, pm_sel}) - $signed({1'b0, pm_q[0]});
    slope_d  = 32'(diff) * $signed({17'd0, mbas_pkg::slope_factor(sel)});
    add_prod = pm_q[0] * mbas_pkg::Div255Mul;
    add_d    = add_prod[mbas_pkg::Div255Shift +: 8];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_en) begin
      slope_q <= slope_d;
      add_q   <= add_d;
    end
  end

  assign slope_o = slope_q;
  assign add_o   = add_q;

endmodule

`default_nettype wire

>>> hw/rtl/mbas_merge.sv
// ----------------------------------------------------------------------------
// mbas_merge
// Sums the lane slopes and scales the result into the clamped blend alpha.
// ----------------------------------------------------------------------------
`default_nettype none

module mbas_merge (
  input  wire logic                      clk_i,
  input  wire mbas_pkg::merge_ctrl_t     ctrl_i,
  input  wire logic signed [2:0][31:0]   slope_i,
  input  wire logic [2:0][7:0]           add_i,
  output mbas_pkg::out_t                 out_o
);

  logic signed [33:0] sum;
  logic signed [34:0] t_full;
  logic [28:0] t3_q, t4_q;
  logic        hi3_q, lo3_q, hi4_q, lo4_q;
  logic [2:0][7:0] add3_q, add4_q;
  logic [56:0] prod_q;
  logic [7:0]  q_est, q_fix;
  logic [28:0] qd, rem;
  mbas_pkg::out_t out_d, out_q;

  always_comb begin
    sum = 34'($signed(slope_i[0])) + 34'($signed(slope_i[1])) + 34'($signed(slope_i[2]));
    t_full = $signed({6'd0, mbas_pkg::ThreeDen}) - 35'(sum);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s3_en) begin
      t3_q   <= t_full[28:0];
      hi3_q  <= (sum <= 34'sd0);
      lo3_q  <= (t_full <= 35'sd0);
      add3_q <= add_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s4_en) begin
      prod_q <= t3_q * mbas_pkg::AlphaRecip;
      t4_q   <= t3_q;
      hi4_q  <= hi3_q;
      lo4_q  <= lo3_q;
      add4_q <= add3_q;
    end
  end

  always_comb begin
    q_est = prod_q[mbas_pkg::RecipShift +: 8];
    qd    = q_est * mbas_pkg::AlphaDiv;
    rem   = t4_q - qd;
    q_fix = (rem >= 29'(mbas_pkg::AlphaDiv)) ? q_est + 8'd1 : q_est;
    out_d.blend_alpha = hi4_q ? 8'd255 : (lo4_q ? 8'd0 : q_fix);
    out_d.add_red     = add4_q[0];
    out_d.add_green   = add4_q[1];
    out_d.add_blue    = add4_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s5_en) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/multi_background_alpha_split_core.sv
// throughput: one item per cycle while out_ready_i is high, set by the five-stage pipeline with no loops
// each stage advances when it is empty or the stage after it advances
// reset: asynchronous active low, clears all stage valid flags
// ----------------------------------------------------------------------------
// multi_background_alpha_split_core
// Three channel lanes and a merge stage split a pixel into blend and add layers.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_background_alpha_split_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire mbas_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output mbas_pkg::out_t       out_data_o
);

  logic [4:0] v_q, v_d;
  logic en1, en2, en3, en4, en5;
  logic [8:0][31:0] samples;
  logic [8:0][7:0]  alpha;
  logic [2:0][8:0][7:0] col;
  logic signed [2:0][31:0] slope;
  logic [2:0][7:0] add;
  mbas_pkg::lane_ctrl_t  lane_ctrl;
  mbas_pkg::merge_ctrl_t merge_ctrl;

  assign en5 = !v_q[4] || out_ready_i;
  assign en4 = !v_q[3] || en5;
  assign en3 = !v_q[2] || en4;
  assign en2 = !v_q[1] || en3;
  assign en1 = !v_q[0] || en2;

  always_comb begin
    v_d = v_q;
    if (en1) v_d[0] = in_valid_i;
    if (en2) v_d[1] = v_q[0];
    if (en3) v_d[2] = v_q[1];
    if (en4) v_d[3] = v_q[2];
    if (en5) v_d[4] = v_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign samples = in_data_i;

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      alpha[j] = samples[j][31:24];
      for (int c = 0; c < 3; c++) begin
        col[c][j] = samples[j][8*c +: 8];
      end
    end
  end

  assign lane_ctrl.s1_en  = en1;
  assign lane_ctrl.s2_en  = en2;
  assign merge_ctrl.s3_en = en3;
  assign merge_ctrl.s4_en = en4;
  assign merge_ctrl.s5_en = en5;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    mbas_lane u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (lane_ctrl),
      .col_i   (col[c]),
      .alpha_i (alpha),
      .slope_o (slope[c]),
      .add_o   (add[c])
    );
  end

  mbas_merge u_merge (
    .clk_i   (clk_i),
    .ctrl_i  (merge_ctrl),
    .slope_i (slope),
    .add_i   (add),
    .out_o   (out_data_o)
  );

  assign in_ready_o  = en1;
  assign out_valid_o = v_q[4];

endmodule

`default_nettype wire

>>> hw/rtl/mbas_checker.sv
// ----------------------------------------------------------------------------
// mbas_port_checks
// Port-level checks of the alpha split core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mbas_port_checks (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire mbas_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_ready_when_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

endmodule

bind multi_background_alpha_split_core mbas_port_checks u_mbas_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
